[rtl/core/lmcs_pkg.sv]
package lmcs_pkg;

    // fixed geometry
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int NBINS           = 16;
    localparam int BIN_W           = 4;
    localparam int PREC            = 11;
    localparam int CW_W            = 18;
    localparam int PIV_W           = 22;
    localparam int SAMPLE_W        = 10;
    localparam int REQ_W           = 2;
    localparam int RES_W           = 16;
    localparam int S_TDATA_W       = 16;
    localparam int S_TUSER_W       = 2;
    localparam int M_TDATA_W       = 16;
    localparam int M_TUSER_W       = 1;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int DELTA_W         = 16;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_FWD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INV    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CHROMA = 2'd2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_BIN    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_BIN    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHROMA_OFS = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DELTA_0    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_DELTA_1    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_DELTA_2    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_DELTA_3    = 3'd6;

    localparam logic [RES_W-1:0] CHROMA_UNITY = 16'd2048;
    localparam logic [RES_W-1:0] RES_SAT      = 16'hFFFF;

    // controller to datapath
    typedef struct packed {
        logic             drv_bin;
        logic             drv_inv;
        logic [BIN_W-1:0] bin;
        logic             div_start;
        logic             div_chroma;
        logic             acc;
        logic             find;
        logic             mul;
        logic             sum;
        logic             cdiv_load;
        logic             out_load;
    } lmcs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cw_pos;
        logic div_done;
        logic is_chroma;
        logic chroma_direct;
        logic out_free;
    } lmcs_sts_t;

endpackage

[rtl/core/lmcs_div.sv]
module lmcs_div
    import lmcs_pkg::*;
#(
    parameter int Q_W = 18,
    parameter int D_W = CW_W
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [Q_W-1:0] quot
);

    localparam int CNT_W = $clog2(Q_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   div_reg;
    logic [Q_W-1:0]   quot_reg;

    logic           bit_in;
    logic [D_W:0]   trial;
    logic [D_W:0]   diff;
    logic           ge;

    // dividend is a single one at its top bit
    assign bit_in = (cnt_reg == CNT_W'(Q_W - 1));
    assign trial  = {rem_reg, bit_in};
    assign diff   = trial - {1'b0, div_reg};
    assign ge     = (trial >= {1'b0, div_reg});

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(Q_W - 1);
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    // one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg  <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
            quot_reg <= {quot_reg[Q_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

`ifndef SYNTHESIS
    a_start_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !done_reg)
        else $error("divider reported done right after start");
`endif

endmodule

[rtl/core/lmcs_datapath.sv]
module lmcs_datapath
    import lmcs_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [S_TUSER_W-1:0]  s_tuser,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [M_TUSER_W-1:0]  m_tuser,
    input  lmcs_cmd_t             cmd,
    output lmcs_sts_t             sts
);

    localparam int LOG2_BIN = SAMPLE_BITS - BIN_W;
    localparam int FWD_W    = CW_W + PREC - LOG2_BIN;
    localparam int INV_W    = LOG2_BIN + PREC + 1;
    localparam int SLP_W    = (FWD_W > INV_W ? FWD_W : INV_W) + 1;
    localparam int STEP_W   = PIV_W + 1;
    localparam int PROD_W   = SLP_W + STEP_W;
    localparam int V_W      = PROD_W + 1;
    localparam int CMP_W    = SAMPLE_BITS > SAMPLE_W ? SAMPLE_BITS : SAMPLE_W;

    localparam logic signed [CW_W-1:0]      ORG_CW   = CW_W'(1) << LOG2_BIN;
    localparam logic [CW_W+PREC-1:0]        HALF_ORG = (CW_W + PREC)'(1) << (LOG2_BIN - 1);
    localparam logic [CMP_W-1:0]            IN_MAX   = CMP_W'((1 << SAMPLE_BITS) - 1);
    localparam logic signed [V_W-1:0]       V_MAX    = V_W'((1 << SAMPLE_BITS) - 1);
    localparam logic signed [PROD_W-1:0]    RND      = PROD_W'(1 << (PREC - 1));

    // configuration registers
    logic [BIN_W-1:0]        min_bin_reg;
    logic [BIN_W:0]          max_bin_reg;
    logic signed [3:0]       ofs_reg;
    logic [CFG_DATA_W-1:0]   delta_reg [4];

    // derived tables
    logic signed [PIV_W-1:0] piv_reg [NBINS];
    logic signed [CW_W-1:0]  cw_reg  [NBINS];
    logic [FWD_W-1:0]        fwd_reg [NBINS];
    logic [INV_W-1:0]        inv_reg [NBINS];

    // item registers
    logic [REQ_W-1:0]         req_reg;
    logic [SAMPLE_BITS-1:0]   x_reg;
    logic [BIN_W-1:0]         idx_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [RES_W-1:0]         res_reg;
    logic                     fault_reg;
    logic                     m_valid_reg;
    logic [RES_W-1:0]         m_res_reg;
    logic                     m_fault_reg;

    logic [BIN_W:0]           hi_bin;
    logic [CFG_DATA_W-1:0]    dword;
    logic [DELTA_W-1:0]       delta_raw;
    logic signed [CW_W-1:0]   delta_ext;
    logic                     active;
    logic signed [CW_W-1:0]   cw_cur;
    logic signed [PIV_W-1:0]  piv_prev;
    logic [CW_W+PREC-1:0]     fwd_num;
    logic                     div_done;
    logic [INV_W-1:0]         div_q;
    logic [CW_W-1:0]          divisor;

    logic [CMP_W-1:0]         s_ext;
    logic [SAMPLE_BITS-1:0]   x_sat;
    logic signed [PIV_W-1:0]  x_s;
    logic [NBINS-1:0]         mask;
    logic [BIN_W:0]           fb5;
    logic [BIN_W-1:0]         found_idx;

    logic signed [PIV_W-1:0]  piv_lo;
    logic signed [SLP_W-1:0]  slope_s;
    logic signed [STEP_W-1:0] step_s;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [CW_W-1:0]   w;
    logic signed [CW_W:0]     d;
    logic                     w_zero;
    logic                     d_nonpos;

    logic signed [PROD_W-1:0] t;
    logic signed [V_W-1:0]    base;
    logic signed [V_W-1:0]    v;
    logic [RES_W-1:0]         clip_res;
    logic [RES_W-1:0]         res_next;
    logic                     fault_next;
    logic                     out_free;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_bin_reg <= '0;
            max_bin_reg <= (BIN_W + 1)'(NBINS);
            ofs_reg     <= '0;
            for (int i = 0; i < 4; i++) begin
                delta_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_MIN_BIN:    min_bin_reg  <= cfg_wr_data[BIN_W-1:0];
                CFG_MAX_BIN:    max_bin_reg  <= cfg_wr_data[BIN_W:0];
                CFG_CHROMA_OFS: ofs_reg      <= cfg_wr_data[3:0];
                CFG_DELTA_0:    delta_reg[0] <= cfg_wr_data;
                CFG_DELTA_1:    delta_reg[1] <= cfg_wr_data;
                CFG_DELTA_2:    delta_reg[2] <= cfg_wr_data;
                CFG_DELTA_3:    delta_reg[3] <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // bin width for the bin under derivation
    assign hi_bin    = (max_bin_reg > (BIN_W + 1)'(NBINS)) ? (BIN_W + 1)'(NBINS) : max_bin_reg;
    assign dword     = delta_reg[cmd.bin[3:2]];
    assign delta_raw = dword[{cmd.bin[1:0], 4'b0000} +: DELTA_W];
    assign delta_ext = {{(CW_W - DELTA_W){delta_raw[DELTA_W-1]}}, delta_raw};
    assign active    = ({1'b0, cmd.bin} >= {1'b0, min_bin_reg}) && ({1'b0, cmd.bin} < hi_bin);
    assign cw_cur    = active ? (ORG_CW + delta_ext) : '0;
    assign piv_prev  = (cmd.bin == '0) ? '0 : piv_reg[cmd.bin - 1'b1];
    assign fwd_num   = {cw_cur, {PREC{1'b0}}} + HALF_ORG;

    // table fill
    always_ff @(posedge aclk) begin
        if (cmd.drv_bin) begin
            piv_reg[cmd.bin] <= piv_prev + {{(PIV_W - CW_W){cw_cur[CW_W-1]}}, cw_cur};
            cw_reg[cmd.bin]  <= cw_cur;
            fwd_reg[cmd.bin] <= (cw_cur > 0) ? fwd_num[CW_W+PREC-1:LOG2_BIN] : '0;
            inv_reg[cmd.bin] <= '0;
        end
        if (cmd.drv_inv) begin
            inv_reg[cmd.bin] <= div_q;
        end
    end

    // shared divider: inverse slopes and chroma scale
    assign divisor = cmd.div_chroma ? d[CW_W-1:0] : cw_cur;

    lmcs_div #(
        .Q_W (INV_W),
        .D_W (CW_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .divisor (divisor),
        .done    (div_done),
        .quot    (div_q)
    );

    // input capture with saturation
    assign s_ext = CMP_W'(s_tdata[SAMPLE_W-1:0]);
    assign x_sat = (s_ext > IN_MAX) ? IN_MAX[SAMPLE_BITS-1:0] : s_ext[SAMPLE_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.acc) begin
            req_reg <= s_tuser;
            x_reg   <= x_sat;
        end
    end

    // bin search over mapped boundaries
    assign x_s = {{(PIV_W - SAMPLE_BITS){1'b0}}, x_reg};

    always_comb begin
        for (int b = 0; b < NBINS; b++) begin
            mask[b] = ((BIN_W + 1)'(b) >= {1'b0, min_bin_reg}) && ((BIN_W + 1)'(b) < hi_bin)
                      && (x_s < piv_reg[b]);
        end
        fb5 = ({1'b0, min_bin_reg} < hi_bin) ? hi_bin : {1'b0, min_bin_reg};
        found_idx = (fb5 > (BIN_W + 1)'(NBINS - 1)) ? BIN_W'(NBINS - 1) : fb5[BIN_W-1:0];
        for (int b = NBINS - 1; b >= 0; b--) begin
            if (mask[b]) begin
                found_idx = BIN_W'(b);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.find) begin
            idx_reg <= (req_reg == REQ_FWD) ? x_reg[SAMPLE_BITS-1 -: BIN_W] : found_idx;
        end
    end

    // slope times offset into the bin
    assign piv_lo = (idx_reg == '0) ? '0 : piv_reg[idx_reg - 1'b1];

    always_comb begin
        if (req_reg == REQ_FWD) begin
            slope_s = {{(SLP_W - FWD_W){1'b0}}, fwd_reg[idx_reg]};
            step_s  = {{(STEP_W - LOG2_BIN){1'b0}}, x_reg[LOG2_BIN-1:0]};
        end else begin
            slope_s = {{(SLP_W - INV_W){1'b0}}, inv_reg[idx_reg]};
            step_s  = {x_s[PIV_W-1], x_s} - {piv_lo[PIV_W-1], piv_lo};
        end
    end

    assign prod_next = slope_s * step_s;

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= prod_next;
        end
    end

    // chroma divisor
    assign w        = cw_reg[idx_reg];
    assign w_zero   = (w == '0);
    assign d        = {w[CW_W-1], w} + {{(CW_W - 3){ofs_reg[3]}}, ofs_reg};
    assign d_nonpos = d[CW_W] || (d == '0);

    // round, add base, clip
    assign t    = (prod_reg + RND) >>> PREC;
    assign base = (req_reg == REQ_FWD) ? {{(V_W - PIV_W){piv_lo[PIV_W-1]}}, piv_lo}
                                       : V_W'({idx_reg, {LOG2_BIN{1'b0}}});
    assign v    = base + {t[PROD_W-1], t};

    always_comb begin
        if (v < 0) begin
            clip_res = '0;
        end else if (v > V_MAX) begin
            clip_res = RES_W'(V_MAX);
        end else begin
            clip_res = RES_W'(v[SAMPLE_BITS-1:0]);
        end
    end

    always_comb begin
        res_next   = '0;
        fault_next = 1'b0;
        case (req_reg)
            REQ_FWD, REQ_INV: res_next = clip_res;
            REQ_CHROMA: begin
                res_next   = w_zero ? CHROMA_UNITY : '0;
                fault_next = !w_zero;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.sum) begin
            res_reg   <= res_next;
            fault_reg <= fault_next;
        end else if (cmd.cdiv_load) begin
            res_reg   <= ({1'b0, div_q} > (INV_W + 1)'(RES_SAT)) ? RES_SAT : div_q[RES_W-1:0];
            fault_reg <= 1'b0;
        end
    end

    // output register
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_res_reg   <= res_reg;
            m_fault_reg <= fault_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_res_reg;
    assign m_tuser  = m_fault_reg;

    assign sts.cw_pos        = (cw_cur > 0);
    assign sts.div_done      = div_done;
    assign sts.is_chroma     = (req_reg == REQ_CHROMA);
    assign sts.chroma_direct = w_zero || d_nonpos;
    assign sts.out_free      = out_free;

`ifndef SYNTHESIS
    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_fault_reg) |-> (m_res_reg == '0))
        else $error("fault item carries a nonzero value");
`endif

endmodule

[rtl/core/lmcs_ctrl.sv]
module lmcs_ctrl
    import lmcs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output lmcs_cmd_t             cmd,
    input  lmcs_sts_t             sts
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_DRV     = 8'b0000_0010,
        S_DRV_DIV = 8'b0000_0100,
        S_FIND    = 8'b0000_1000,
        S_MUL     = 8'b0001_0000,
        S_SUM     = 8'b0010_0000,
        S_CDIV    = 8'b0100_0000,
        S_OUT     = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [BIN_W-1:0] bin_reg, bin_next;
    logic             restart;
    logic             last_bin;

    // a register write rebuilds the tables
    assign restart  = cfg_wr_en && (cfg_addr <= CFG_DELTA_3);
    assign last_bin = (bin_reg == BIN_W'(NBINS - 1));
    assign s_tready = (state_reg == S_IDLE) && !restart;

    always_comb begin
        state_next = state_reg;
        bin_next   = bin_reg;
        cmd        = '0;
        cmd.bin    = bin_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && !restart) begin
                    cmd.acc    = 1'b1;
                    state_next = S_FIND;
                end
            end
            S_DRV: begin
                cmd.drv_bin = 1'b1;
                if (sts.cw_pos) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DRV_DIV;
                end else if (last_bin) begin
                    state_next = S_IDLE;
                end else begin
                    bin_next = bin_reg + 1'b1;
                end
            end
            S_DRV_DIV: begin
                if (sts.div_done) begin
                    cmd.drv_inv = 1'b1;
                    if (last_bin) begin
                        state_next = S_IDLE;
                    end else begin
                        bin_next   = bin_reg + 1'b1;
                        state_next = S_DRV;
                    end
                end
            end
            S_FIND: begin
                cmd.find   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                if (sts.is_chroma && !sts.chroma_direct) begin
                    cmd.div_start  = 1'b1;
                    cmd.div_chroma = 1'b1;
                    state_next     = S_CDIV;
                end else begin
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                cmd.sum    = 1'b1;
                state_next = S_OUT;
            end
            S_CDIV: begin
                if (sts.div_done) begin
                    cmd.cdiv_load = 1'b1;
                    state_next    = S_OUT;
                end
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_DRV;
        endcase
        if (restart) begin
            state_next = S_DRV;
            bin_next   = '0;
        end
    end

    // state and bin counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_DRV;
            bin_reg   <= '0;
        end else begin
            state_reg <= state_next;
            bin_reg   <= bin_next;
        end
    end

`ifndef SYNTHESIS
    a_acc_to_find: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_FIND))
        else $error("accepted item did not start the bin search");

    a_out_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && sts.out_free && !restart) |=> (state_reg == S_IDLE))
        else $error("result not released to the output register");

    a_div_start_place: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> (state_reg == S_DRV || state_reg == S_MUL))
        else $error("divider started outside derivation or chroma path");
`endif

endmodule

[rtl/core/lmcs_luma_map_chroma_scale_core.sv]
// an item is taken only in IDLE; a mapped sample then passes FIND, MUL, SUM and OUT
// chroma scale items that need the serial divider go from MUL through CDIV to OUT
// the divider delivers one quotient bit per cycle and sets the chroma item time
// after reset and after every register write the bin tables are rebuilt, one bin per
// cycle plus the divider run for each bin with a positive codeword
// reset is synchronous, active low; s_tready stays low until the tables are built
module lmcs_luma_map_chroma_scale_core
    import lmcs_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,      // sample_value[9:0]
    input  logic [S_TUSER_W-1:0]  s_tuser,      // req_type[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,      // result_value[15:0]
    output logic [M_TUSER_W-1:0]  m_tuser,      // div_fault[0]
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    lmcs_cmd_t cmd;
    lmcs_sts_t sts;

    lmcs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    lmcs_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule
